// ===== rtl/core/spmc_pkg.sv =====
package spmc_pkg;

  localparam int MAX_BONES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;

  typedef struct packed {
    logic       in_wr;
    logic       start;
    logic       rd_en;
    logic [1:0] rd_row;
    logic       mul_en;
    logic       mul_sel;
    logic [3:0] mul_idx;
    logic       st_en;
    logic [1:0] st_row;
    logic [1:0] out_row;
  } spmc_cmd_t;

  typedef struct packed {
    logic completes;
    logic bone_ok;
  } spmc_status_t;

endpackage

// ===== rtl/core/spmc_datapath.sv =====
module spmc_datapath #(
  parameter int MAX_BONES = spmc_pkg::MAX_BONES_DEF,
  parameter int FRAC_BITS = spmc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spmc_pkg::spmc_cmd_t         cmd,
  output spmc_pkg::spmc_status_t      status,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_req_type,
  input  logic [5:0]                  in_bone,
  input  logic signed [6:0]           in_parent_bone,
  input  logic [1:0]                  in_row,
  input  logic signed [31:0]          in_elem0,
  input  logic signed [31:0]          in_elem1,
  input  logic signed [31:0]          in_elem2,
  input  logic signed [31:0]          in_elem3,
  output logic [5:0]                  out_bone,
  output logic [1:0]                  out_row,
  output logic signed [31:0]          out0,
  output logic signed [31:0]          out1,
  output logic signed [31:0]          out2,
  output logic signed [31:0]          out3,
  output logic                        out_last
);

  localparam int BW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int DEPTH = MAX_BONES * 4;
  localparam int AW    = BW + 2;
  localparam int RW    = 4 * spmc_pkg::WORD_W;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic [RW-1:0] gmem  [DEPTH];
  logic [RW-1:0] ibmem [DEPTH];

  logic signed [31:0] loc_r [4][4];
  logic signed [31:0] pa_r  [4][4];
  logic signed [31:0] ib_r  [4][4];
  logic signed [31:0] g_r   [4][4];
  logic signed [31:0] o_r   [4][4];

  logic [MAX_BONES-1:0] gvalid_r;
  logic                 apply_r;
  logic [BW-1:0]        bone_r;
  logic [5:0]           obone_r;
  logic [BW-1:0]        par_r;
  logic                 root_r;
  logic                 pv_r;
  logic [RW-1:0]        gq_r;
  logic [RW-1:0]        ibq_r;
  logic                 rd_v_r;
  logic [1:0]           rd_row_d_r;
  logic signed [63:0]   prod_r [4];
  logic                 mul_v_r;
  logic                 sel_d_r;
  logic [3:0]           idx_d_r;

  logic [8:0]         bone_x;
  logic [8:0]         par_x;
  logic               par_ok;
  logic signed [31:0] a_w [4];
  logic signed [31:0] b_w [4];
  logic signed [65:0] sum_w;
  logic signed [65:0] sh_w;
  logic signed [31:0] res_w;

  assign bone_x = {3'b000, in_bone};
  assign par_x  = {2'b00, in_parent_bone};
  assign par_ok = !in_parent_bone[6] && (par_x < 9'(MAX_BONES));

  assign status.bone_ok   = bone_x < 9'(MAX_BONES);
  assign status.completes = status.bone_ok && in_req_type && (in_row == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apply_r  <= 1'b1;
      gvalid_r <= '0;
      rd_v_r   <= 1'b0;
      mul_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        apply_r <= cfg_wdata;
      end
      if (cmd.st_en) begin
        gvalid_r[bone_r] <= 1'b1;
      end
      rd_v_r  <= cmd.rd_en;
      mul_v_r <= cmd.mul_en;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.in_wr && status.bone_ok && !in_req_type) begin
      ibmem[{bone_x[BW-1:0], in_row}] <= {in_elem3, in_elem2, in_elem1, in_elem0};
    end
    if (cmd.st_en) begin
      gmem[{bone_r, cmd.st_row}] <= {g_r[cmd.st_row][3], g_r[cmd.st_row][2],
                                     g_r[cmd.st_row][1], g_r[cmd.st_row][0]};
    end
    if (cmd.rd_en) begin
      gq_r  <= gmem[AW'({par_r, cmd.rd_row})];
      ibq_r <= ibmem[AW'({bone_r, cmd.rd_row})];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_wr && status.bone_ok && in_req_type) begin
      loc_r[in_row][0] <= in_elem0;
      loc_r[in_row][1] <= in_elem1;
      loc_r[in_row][2] <= in_elem2;
      loc_r[in_row][3] <= in_elem3;
    end
    if (cmd.start) begin
      bone_r  <= bone_x[BW-1:0];
      obone_r <= in_bone;
      par_r   <= par_x[BW-1:0];
      root_r  <= !par_ok;
      pv_r    <= par_ok ? gvalid_r[par_x[BW-1:0]] : 1'b0;
    end
    rd_row_d_r <= cmd.rd_row;
    // roots take identity as parent; a skipped inverse bind is identity too
    if (rd_v_r) begin
      for (int c = 0; c < 4; c++) begin
        if (root_r) begin
          pa_r[rd_row_d_r][c] <= (rd_row_d_r == 2'(c)) ? ONE : 32'sd0;
        end else if (pv_r) begin
          pa_r[rd_row_d_r][c] <= gq_r[c*32 +: 32];
        end else begin
          pa_r[rd_row_d_r][c] <= 32'sd0;
        end
        if (apply_r) begin
          ib_r[rd_row_d_r][c] <= ibq_r[c*32 +: 32];
        end else begin
          ib_r[rd_row_d_r][c] <= (rd_row_d_r == 2'(c)) ? ONE : 32'sd0;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_w[k] = cmd.mul_sel ? g_r[cmd.mul_idx[3:2]][k] : pa_r[cmd.mul_idx[3:2]][k];
      b_w[k] = cmd.mul_sel ? ib_r[k][cmd.mul_idx[1:0]] : loc_r[k][cmd.mul_idx[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      prod_r[k] <= a_w[k] * b_w[k];
    end
    sel_d_r <= cmd.mul_sel;
    idx_d_r <= cmd.mul_idx;
  end

  always_comb begin
    sum_w = 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2]) + 66'(prod_r[3]);
    sh_w  = sum_w >>> FRAC_BITS;
    if (sh_w > 66'sd2147483647) begin
      res_w = 32'sh7fffffff;
    end else if (sh_w < -66'sd2147483648) begin
      res_w = 32'sh80000000;
    end else begin
      res_w = sh_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mul_v_r) begin
      if (sel_d_r) begin
        o_r[idx_d_r[3:2]][idx_d_r[1:0]] <= res_w;
      end else begin
        g_r[idx_d_r[3:2]][idx_d_r[1:0]] <= res_w;
      end
    end
  end

  assign out_bone = obone_r;
  assign out_row  = cmd.out_row;
  assign out0     = o_r[cmd.out_row][0];
  assign out1     = o_r[cmd.out_row][1];
  assign out2     = o_r[cmd.out_row][2];
  assign out3     = o_r[cmd.out_row][3];
  assign out_last = (cmd.out_row == 2'd3);

endmodule

// ===== rtl/core/spmc_ctrl.sv =====
module spmc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  spmc_pkg::spmc_status_t status,
  output spmc_pkg::spmc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL1,
    S_STORE,
    S_MUL2,
    S_SEND
  } state_t;

  state_t     state_r;
  logic [4:0] cnt_r;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && status.completes) begin
            state_r <= S_LOAD;
            cnt_r   <= '0;
          end
        end
        S_LOAD: begin
          if (cnt_r == 5'd4) begin
            state_r <= S_MUL1;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_MUL1: begin
          if (cnt_r == 5'd16) begin
            state_r <= S_STORE;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_STORE: begin
          if (cnt_r == 5'd3) begin
            state_r <= S_MUL2;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_MUL2: begin
          if (cnt_r == 5'd16) begin
            state_r <= S_SEND;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SEND: begin
          if (out_ready) begin
            if (cnt_r == 5'd3) begin
              state_r <= S_IDLE;
              cnt_r   <= '0;
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
          cnt_r   <= '0;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SEND);
  assign accept    = in_valid && in_ready;

  // last count of each multiply pass only drains the accumulate stage
  always_comb begin
    cmd.in_wr   = accept;
    cmd.start   = accept && status.completes;
    cmd.rd_en   = (state_r == S_LOAD) && (cnt_r < 5'd4);
    cmd.rd_row  = cnt_r[1:0];
    cmd.mul_en  = ((state_r == S_MUL1) || (state_r == S_MUL2)) && !cnt_r[4];
    cmd.mul_sel = (state_r == S_MUL2);
    cmd.mul_idx = cnt_r[3:0];
    cmd.st_en   = (state_r == S_STORE);
    cmd.st_row  = cnt_r[1:0];
    cmd.out_row = cnt_r[1:0];
  end

endmodule

// ===== rtl/core/skeleton_pose_matrix_chain.sv =====
// Flow: a local row 3 offers its first output row after the load, the first multiply
//   pass, the store and the second pass, then one row per cycle while out_ready holds;
//   other items are taken without starting a computation. No new item is taken until
//   the last row is sent; work runs through one four-multiplier dot unit running both
//   4x4 products element by element, plus row-wide memory loads.
// Reset: synchronous, active low; global matrices read as zero until written,
//   apply_inverse_bind resets to 1.
module skeleton_pose_matrix_chain #(
  parameter int MAX_BONES = spmc_pkg::MAX_BONES_DEF,
  parameter int FRAC_BITS = spmc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [5:0]         in_bone,
  input  logic signed [6:0]  in_parent_bone,
  input  logic [1:0]         in_row,
  input  logic signed [31:0] in_elem0,
  input  logic signed [31:0] in_elem1,
  input  logic signed [31:0] in_elem2,
  input  logic signed [31:0] in_elem3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_bone,
  output logic [1:0]         out_row,
  output logic signed [31:0] out0,
  output logic signed [31:0] out1,
  output logic signed [31:0] out2,
  output logic signed [31:0] out3,
  output logic               out_last
);

  spmc_pkg::spmc_cmd_t    cmd;
  spmc_pkg::spmc_status_t status;

  spmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  spmc_datapath #(
    .MAX_BONES (MAX_BONES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req_type),
    .in_bone        (in_bone),
    .in_parent_bone (in_parent_bone),
    .in_row         (in_row),
    .in_elem0       (in_elem0),
    .in_elem1       (in_elem1),
    .in_elem2       (in_elem2),
    .in_elem3       (in_elem3),
    .out_bone       (out_bone),
    .out_row        (out_row),
    .out0           (out0),
    .out1           (out1),
    .out2           (out2),
    .out3           (out3),
    .out_last       (out_last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_bone_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && status.completes) |=> !in_ready)
    else $error("completed bone did not start computation");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_row == $past(out_row) + 2'd1))
    else $error("output rows out of order");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("no return to idle after last row");

endmodule

// ===== tb/tb_skeleton_pose_matrix_chain.sv =====
module tb_skeleton_pose_matrix_chain;

  localparam int FRAC      = spmc_pkg::FRAC_BITS_DEF;
  localparam int NBONES    = spmc_pkg::MAX_BONES_DEF;
  localparam int WDOG_MAX  = 3000;
  localparam int SETTLE    = 60;
  localparam int HOLD_LEN  = 300;
  localparam logic REQ_IBIND = 1'b0;
  localparam logic REQ_LOCAL = 1'b1;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [spmc_pkg::WORD_W-1:0] word_t;
  typedef word_t mat_t [16];

  typedef struct {
    logic [5:0] bone;
    logic [1:0] row;
    word_t      col [4];
    logic       last;
  } pose_row_t;

  typedef struct {
    logic              req;
    logic [5:0]        bone;
    logic signed [6:0] parent;
    logic [1:0]        row;
    word_t             d;
    logic              has_exp;
    word_t             exp_d;
  } dir_row_t;

  logic clk, rst_n;
  logic cfg_we, cfg_wdata;
  logic in_valid, in_ready, in_req_type;
  logic [5:0] in_bone;
  logic signed [6:0] in_parent_bone;
  logic [1:0] in_row;
  logic signed [31:0] in_elem0, in_elem1, in_elem2, in_elem3;
  logic out_valid, out_ready;
  logic [5:0] out_bone;
  logic [1:0] out_row;
  logic signed [31:0] out0, out1, out2, out3;
  logic out_last;

  skeleton_pose_matrix_chain dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_bone(in_bone), .in_parent_bone(in_parent_bone), .in_row(in_row),
    .in_elem0(in_elem0), .in_elem1(in_elem1), .in_elem2(in_elem2),
    .in_elem3(in_elem3), .out_valid(out_valid), .out_ready(out_ready),
    .out_bone(out_bone), .out_row(out_row), .out0(out0), .out1(out1),
    .out2(out2), .out3(out3), .out_last(out_last)
  );

  // predictor state
  word_t local_m [16];
  word_t global_m [NBONES][16];
  word_t ibind_m [NBONES][16];
  logic  apply_ib;
  logic [3:0] local_seen;
  logic [3:0] ibind_seen [NBONES];

  pose_row_t pose_q [$];
  int errors, rows_checked, items_sent;
  int send_idle, recv_idle, hold_left, wdog;
  bit hold_go;
  dir_row_t dir_tab [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t dot_sat(word_t a [4], word_t b [4]);
    logic signed [65:0] acc, s;
    acc = '0;
    for (int k = 0; k < 4; k++) acc = acc + a[k] * b[k];
    s = acc >>> FRAC;
    if (s > 66'sd2147483647) return Q_MAX;
    if (s < -66'sd2147483648) return Q_MIN;
    return s[31:0];
  endfunction

  function automatic mat_t mat_mul(mat_t a, mat_t b);
    mat_t r;
    word_t ra [4], cb [4];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          ra[k] = a[i*4+k];
          cb[k] = b[k*4+j];
        end
        r[i*4+j] = dot_sat(ra, cb);
      end
    return r;
  endfunction

  // update the model with one accepted row and queue any pose rows it yields
  task automatic predict_row(logic req, logic [5:0] bone, logic signed [6:0] parent,
                             logic [1:0] row, word_t e [4], logic has_exp, word_t exp_d);
    mat_t g, o, pm;
    pose_row_t pr;
    if (req == REQ_IBIND) begin
      for (int c = 0; c < 4; c++) ibind_m[bone][row*4+c] = e[c];
      ibind_seen[bone][row] = 1'b1;
      return;
    end
    for (int c = 0; c < 4; c++) local_m[row*4+c] = e[c];
    local_seen[row] = 1'b1;
    if (row != 2'd3) return;
    if (parent >= 0) begin
      pm = global_m[parent];
      g = mat_mul(pm, local_m);
    end else begin
      g = local_m;
    end
    global_m[bone] = g;
    if (apply_ib) begin
      pm = ibind_m[bone];
      o = mat_mul(g, pm);
    end else begin
      o = g;
    end
    for (int k = 0; k < 4; k++) begin
      pr.bone = bone;
      pr.row = 2'(k);
      pr.last = (k == 3);
      for (int c = 0; c < 4; c++)
        pr.col[c] = has_exp ? ((k == c) ? exp_d : '0) : o[k*4+c];
      pose_q = {pose_q, pr};
    end
  endtask

  // returns on the transfer edge with valid still high
  task automatic send_row(logic req, logic [5:0] bone, logic signed [6:0] parent,
                          logic [1:0] row, word_t e [4], logic has_exp, word_t exp_d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_bone        <= bone;
    in_parent_bone <= parent;
    in_row         <= row;
    in_elem0       <= e[0];
    in_elem1       <= e[1];
    in_elem2       <= e[2];
    in_elem3       <= e[3];
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
    predict_row(req, bone, parent, row, e, has_exp, exp_d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_ib  = v;
  endtask

  function automatic word_t rand_elem();
    int v;
    case ($urandom_range(9))
      0: return word_t'($urandom);
      1: return $urandom_range(1) ? Q_MAX : Q_MIN;
      default: begin
        v = int'($urandom_range(262143)) - 131072;
        return word_t'(v);
      end
    endcase
  endfunction

  task automatic send_rand(logic req, logic [5:0] bone, logic signed [6:0] parent,
                           logic [1:0] row);
    word_t e [4];
    for (int c = 0; c < 4; c++) e[c] = rand_elem();
    send_row(req, bone, parent, row, e, 1'b0, '0);
  endtask

  task automatic rand_bone();
    logic [5:0] bone;
    logic signed [6:0] parent;
    int shape;
    bone = 6'($urandom_range(NBONES-1));
    if ($urandom_range(9) == 0)
      parent = 7'($urandom_range(127));
    else if (bone == 0 || $urandom_range(3) == 0)
      parent = -7'sd1;
    else
      parent = 7'($urandom_range(bone - 1));
    if ($urandom_range(4) == 0)
      send_rand(REQ_IBIND, bone, parent, 2'($urandom_range(3)));
    if (apply_ib)
      for (int r = 0; r < 4; r++)
        if (!ibind_seen[bone][r]) send_rand(REQ_IBIND, bone, parent, 2'(r));
    shape = (local_seen == 4'hf) ? $urandom_range(9) : 0;
    if (shape == 9) begin
      send_rand(REQ_LOCAL, bone, parent, 2'd3);
    end else if (shape == 8) begin
      send_rand(REQ_LOCAL, bone, parent, 2'($urandom_range(2)));
      send_rand(REQ_LOCAL, bone, parent, 2'd3);
    end else begin
      for (int r = 0; r < 4; r++) send_rand(REQ_LOCAL, bone, parent, 2'(r));
    end
  endtask

  task automatic report_mismatch(string what, pose_row_t x, longint got, longint want);
    $display("mismatch %s bone %0d row %0d: got %0h want %0h", what, x.bone, x.row,
             got, want);
    errors++;
  endtask

  // result side: check transfers and drive out_ready
  always @(posedge clk) begin
    pose_row_t x;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $display("unexpected pose row bone %0d row %0d", out_bone, out_row);
          errors++;
        end else begin
          x = pose_q.pop_front();
          rows_checked++;
          if (out_bone !== x.bone) report_mismatch("bone", x, out_bone, x.bone);
          if (out_row !== x.row) report_mismatch("row", x, out_row, x.row);
          if (out_last !== x.last) report_mismatch("last", x, out_last, x.last);
          if (out0 !== x.col[0]) report_mismatch("col0", x, out0, x.col[0]);
          if (out1 !== x.col[1]) report_mismatch("col1", x, out1, x.col[1]);
          if (out2 !== x.col[2]) report_mismatch("col2", x, out2, x.col[2]);
          if (out3 !== x.col[3]) report_mismatch("col3", x, out3, x.col[3]);
        end
      end
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired, %0d pose rows outstanding", pose_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_dir(logic req, logic [5:0] bone, logic signed [6:0] parent,
                         logic [1:0] row, word_t d, logic has_exp, word_t exp_d);
    dir_row_t t;
    t.req = req; t.bone = bone; t.parent = parent; t.row = row; t.d = d;
    t.has_exp = has_exp; t.exp_d = exp_d;
    dir_tab = {dir_tab, t};
  endtask

  initial begin
    word_t e [4];
    int target;
    bit held;
    errors = 0; rows_checked = 0; items_sent = 0; wdog = 0;
    hold_go = 1'b0; hold_left = 0; held = 1'b0;
    send_idle = 0; recv_idle = 0;
    apply_ib = 1'b1; local_seen = '0;
    for (int b = 0; b < NBONES; b++) begin
      ibind_seen[b] = '0;
      for (int w = 0; w < 16; w++) begin
        global_m[b][w] = '0;
        ibind_m[b][w] = '0;
      end
    end
    for (int w = 0; w < 16; w++) local_m[w] = '0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 1'b0; in_valid = 1'b0;
    in_req_type = 1'b0; in_bone = '0; in_parent_bone = '0; in_row = '0;
    in_elem0 = '0; in_elem1 = '0; in_elem2 = '0; in_elem3 = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity root, then saturating products, then self and lower parents
    for (int r = 0; r < 4; r++)
      add_dir(REQ_IBIND, 6'd0, 7'sd0, 2'(r), Q_ONE, 1'b0, '0);
    for (int r = 0; r < 4; r++)
      add_dir(REQ_LOCAL, 6'd0, -7'sd1, 2'(r), Q_ONE, r == 3, Q_ONE);
    for (int r = 0; r < 4; r++)
      add_dir(REQ_IBIND, 6'd1, 7'sd0, 2'(r), Q_MAX, 1'b0, '0);
    for (int r = 0; r < 4; r++)
      add_dir(REQ_LOCAL, 6'd1, -7'sd1, 2'(r), Q_MAX, r == 3, Q_MAX);
    for (int r = 0; r < 4; r++)
      add_dir(REQ_LOCAL, 6'd1, 7'sh40, 2'(r), Q_MIN, r == 3, Q_MIN);
    add_dir(REQ_LOCAL, 6'd1, 7'sd1, 2'd3, Q_MIN, 1'b1, Q_MAX);
    add_dir(REQ_LOCAL, 6'd1, 7'sd0, 2'd3, Q_MIN, 1'b1, Q_MIN);
    add_dir(REQ_LOCAL, 6'd63, 7'sd63, 2'd3, Q_MIN, 1'b0, '0);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].bone == 63) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) e[c] = (c == r) ? Q_MAX : Q_MIN;
          send_row(REQ_IBIND, 6'd63, 7'sd0, 2'(r), e, 1'b0, '0);
        end
      end
      for (int c = 0; c < 4; c++) e[c] = (c == dir_tab[i].row) ? dir_tab[i].d : '0;
      send_row(dir_tab[i].req, dir_tab[i].bone, dir_tab[i].parent, dir_tab[i].row,
               e, dir_tab[i].has_exp, dir_tab[i].exp_d);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(ph[0] == 1'b0);
      send_idle = (ph == 0) ? 16 : (ph == 1) ? 82 : 0;
      recv_idle = (ph == 0) ? 82 : (ph == 1) ? 16 : 0;
      target = items_sent + 100;
      while (items_sent < target) begin
        if (ph == 2 && !held && items_sent >= target - 80) begin
          hold_go = 1'b1;
          held = 1'b1;
        end
        rand_bone();
      end
      drain();
    end

    $display("sent %0d rows (inverse bind and local), checked %0d pose rows",
             items_sent, rows_checked);
    $display("covered root, chained, self and out-of-order parents, both output modes");
    if (errors == 0 && pose_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
